@@ hw/rtl/pcp_pkg.sv @@
// ---------------------------------------------------------------------------
// pcp_pkg
// shared widths, register codes, types and helpers of the capsule push-out
// ---------------------------------------------------------------------------
package pcp_pkg;

    localparam int CW  = 32;          // coordinate width
    localparam int FB  = 16;          // fraction bits
    localparam int RW  = CW - 1;      // radius width
    localparam int AW  = CW + 1;      // difference width
    localparam int PW  = 2 * AW;      // product of two differences
    localparam int SW  = PW + 2;      // sum of three products
    localparam int TW  = FB + 1;      // projection parameter width
    localparam int OW  = AW + 1;      // offset along the axis
    localparam int DW  = CW + 5;      // vertex to closest point
    localparam int D2W = 2 * RW;      // squared distance inside the radius
    localparam int QW  = CW + 1;      // push quotient width
    localparam int QD  = 4;           // queue depth
    localparam int QAW = $clog2(QD);

    typedef enum logic [2:0] {
        REG_END_A_X,
        REG_END_A_Y,
        REG_END_A_Z,
        REG_END_B_X,
        REG_END_B_Y,
        REG_END_B_Z,
        REG_CAP_RADIUS
    } t_cfg_idx;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] az;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] bz;
        logic [RW-1:0]        radius;
    } t_capsule;

    // one classified vertex between front and back
    typedef struct packed {
        logic [2:0][CW-1:0] p;
        logic [2:0]         dn;
        logic [2:0][RW-1:0] dm;
        logic [D2W-1:0]     d2;
        logic               hit;
    } t_geo;

    function automatic logic [AW-1:0] mag_a(input logic signed [AW-1:0] v);
        return v[AW-1] ? AW'(-v) : AW'(v);
    endfunction

    function automatic logic [CW-1:0] sat_coord(input logic signed [CW+2:0] v);
        logic signed [CW+2:0] hi;
        logic signed [CW+2:0] lo;
        hi = (CW+3)'({1'b0, {(CW-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi) return CW'(hi);
        if (v < lo) return CW'(lo);
        return CW'(v);
    endfunction

endpackage

@@ hw/rtl/pcp_front.sv @@
// ---------------------------------------------------------------------------
// pcp_front
// projects the vertex onto the segment and classifies it against the radius
// ---------------------------------------------------------------------------
module pcp_front import pcp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_capsule             i_cap,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [CW-1:0] i_px,
    input  logic signed [CW-1:0] i_py,
    input  logic signed [CW-1:0] i_pz,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_geo                 o_geo
);

    localparam int FN     = FB + 9;
    localparam int ST_D   = FB + 6;

    logic                 en;
    logic [FN-1:0]        r_vld;
    logic signed [CW-1:0] a [3];
    logic signed [CW-1:0] b [3];
    logic signed [AW-1:0] ab [3];
    logic [AW-1:0]        abm [3];
    logic [2:0]           abn;

    logic signed [CW-1:0] r_p [FN-1][3];
    logic signed [AW-1:0] r_ap [3];
    logic [PW-1:0]        r_pr [3];
    logic [PW-1:0]        r_sq [3];
    logic [2:0]           r_prn;
    logic [SW-1:0]        r_pos, r_neg, r_ab2;
    logic [SW-1:0]        r_rem [FB+1];
    logic [SW-1:0]        r_den [FB+1];
    logic [FB-1:0]        r_q [FB+1];
    logic [FB:0]          r_tz, r_to;
    logic [TW+AW-1:0]     r_off [3];
    logic signed [DW-1:0] r_d [3];
    logic [D2W-1:0]       r_dsq [3];
    logic [RW-1:0]        r_dm [3];
    logic [2:0]           r_dn;
    logic                 r_big;
    logic [D2W-1:0]       r_r2;
    t_geo                 r_geo;

    logic [SW-1:0]        w_dot;
    logic                 w_tz, w_to;
    logic [TW-1:0]        w_t;
    logic signed [DW-1:0] w_d [3];
    logic [DW-1:0]        w_dmag [3];
    logic                 w_big;
    logic [D2W+1:0]       w_d2;

    assign en      = !r_vld[FN-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[FN-1];
    assign o_geo   = r_geo;

    always_comb begin
        a = '{i_cap.ax, i_cap.ay, i_cap.az};
        b = '{i_cap.bx, i_cap.by, i_cap.bz};
        for (int i = 0; i < 3; i++) begin
            ab[i]  = AW'(b[i]) - AW'(a[i]);
            abm[i] = mag_a(ab[i]);
            abn[i] = ab[i][AW-1];
        end
    end

    // projection parameter selection
    always_comb begin
        w_dot = r_pos - r_neg;
        w_tz  = (r_ab2 == '0) || !(r_neg < r_pos);
        w_to  = !w_tz && (w_dot >= r_ab2);
        if (r_to[FB]) begin
            w_t = TW'(1) << FB;
        end else if (r_tz[FB]) begin
            w_t = '0;
        end else begin
            w_t = {1'b0, r_q[FB]};
        end
    end

    // offset from the closest point, magnitude checks and squared distance
    always_comb begin
        logic [OW-1:0]        off;
        logic signed [DW-1:0] offs;
        w_big = 1'b0;
        for (int i = 0; i < 3; i++) begin
            off       = r_off[i][TW+AW-1:FB];
            offs      = $signed(DW'(off));
            w_d[i]    = DW'(r_p[ST_D-1][i]) - DW'(a[i]) + (abn[i] ? offs : -offs);
            w_dmag[i] = r_d[i][DW-1] ? DW'(-r_d[i]) : DW'(r_d[i]);
            w_big     = w_big | (|w_dmag[i][DW-1:RW]);
        end
        w_d2 = (D2W+2)'(r_dsq[0]) + (D2W+2)'(r_dsq[1]) + (D2W+2)'(r_dsq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[FN-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2 <= i_cap.radius * i_cap.radius;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= '{i_px, i_py, i_pz};
            for (int s = 1; s < FN - 1; s++) r_p[s] <= r_p[s-1];
            for (int i = 0; i < 3; i++) begin
                r_ap[i]  <= AW'(r_p[0][i]) - AW'(a[i]);
                r_pr[i]  <= mag_a(r_ap[i]) * abm[i];
                r_sq[i]  <= abm[i] * abm[i];
                r_prn[i] <= r_ap[i][AW-1] ^ abn[i];
                r_off[i] <= w_t * abm[i];
                r_d[i]   <= w_d[i];
                r_dm[i]  <= w_dmag[i][RW-1:0];
                r_dn[i]  <= r_d[i][DW-1];
                r_dsq[i] <= w_dmag[i][RW-1:0] * w_dmag[i][RW-1:0];
            end
            r_pos <= (r_prn[0] ? '0 : SW'(r_pr[0])) + (r_prn[1] ? '0 : SW'(r_pr[1]))
                   + (r_prn[2] ? '0 : SW'(r_pr[2]));
            r_neg <= (r_prn[0] ? SW'(r_pr[0]) : '0) + (r_prn[1] ? SW'(r_pr[1]) : '0)
                   + (r_prn[2] ? SW'(r_pr[2]) : '0);
            r_ab2 <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_rem[0] <= w_dot;
            r_den[0] <= r_ab2;
            r_q[0]   <= '0;
            r_tz[0]  <= w_tz;
            r_to[0]  <= w_to;
            r_big    <= w_big;
            for (int i = 0; i < 3; i++) begin
                r_geo.p[i]  <= r_p[FN-2][i];
                r_geo.dm[i] <= r_dm[i];
            end
            r_geo.dn  <= r_dn;
            r_geo.d2  <= w_d2[D2W-1:0];
            r_geo.hit <= !r_big && (w_d2 < (D2W+2)'(r_r2));
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 1; k <= FB; k++) begin : g_div
        logic [SW:0] rem2;
        logic        ge;
        assign rem2 = {r_rem[k-1], 1'b0};
        assign ge   = rem2 >= {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[k] <= ge ? SW'(rem2 - {1'b0, r_den[k-1]}) : SW'(rem2);
                r_den[k] <= r_den[k-1];
                r_q[k]   <= {r_q[k-1][FB-2:0], ge};
                r_tz[k]  <= r_tz[k-1];
                r_to[k]  <= r_to[k-1];
            end
        end
    end

endmodule

@@ hw/rtl/pcp_fifo.sv @@
// ---------------------------------------------------------------------------
// pcp_fifo
// short queue between the classify front and the push back
// ---------------------------------------------------------------------------
module pcp_fifo import pcp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_geo i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_geo o_data
);

    t_geo           mem [QD];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_cnt;
    logic           push, pop;

    assign o_ready = r_cnt != (QAW+1)'(QD);
    assign o_valid = r_cnt != '0;
    assign o_data  = mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

endmodule

@@ hw/rtl/pcp_back.sv @@
// ---------------------------------------------------------------------------
// pcp_back
// square root of the distance, push-out division and saturation
// ---------------------------------------------------------------------------
module pcp_back import pcp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [RW-1:0] i_radius,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_geo          i_geo,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [CW-1:0] o_x,
    output logic [CW-1:0] o_y,
    output logic [CW-1:0] o_z,
    output logic          o_hit
);

    localparam int BN     = RW + QW + 3;
    localparam int ST_PEN = RW + 1;

    logic           en;
    logic [BN-1:0]  r_vld;
    t_geo           r_g [BN-1];
    logic [D2W-1:0] r_srem [RW+1];
    logic [RW-1:0]  r_res [RW+1];
    logic [RW-1:0]  r_dist [QW+1];
    logic [QW:0]    r_zero;
    logic [RW-1:0]  r_drem [3][QW+1];
    logic [QW-1:0]  r_nlo [3][QW+1];
    logic [QW-1:0]  r_q [3][QW+1];
    logic [CW-1:0]  r_out [3];
    logic           r_hit;

    logic [RW-1:0]  w_pen;
    logic [D2W-1:0] w_prod [3];
    logic [CW-1:0]  w_out [3];

    assign en      = !r_vld[BN-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[BN-1];
    assign o_x     = r_out[0];
    assign o_y     = r_out[1];
    assign o_z     = r_out[2];
    assign o_hit   = r_hit;

    always_comb begin
        w_pen = i_radius - r_res[RW];
        for (int i = 0; i < 3; i++) w_prod[i] = r_g[ST_PEN-1].dm[i] * w_pen;
    end

    // final correction and clamp
    always_comb begin
        t_geo                 g;
        logic signed [CW+2:0] m;
        g = r_g[BN-2];
        for (int i = 0; i < 3; i++) begin
            m        = $signed((CW+3)'(r_q[i][QW]));
            w_out[i] = g.p[i];
            if (g.hit && !r_zero[QW]) begin
                w_out[i] = sat_coord((CW+3)'($signed(g.p[i])) + (g.dn[i] ? -m : m));
            end
        end
        if (g.hit && r_zero[QW]) begin
            w_out[1] = sat_coord((CW+3)'($signed(g.p[1])) + $signed((CW+3)'(i_radius)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[BN-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g[0] <= i_geo;
            for (int s = 1; s < BN - 1; s++) r_g[s] <= r_g[s-1];
            r_srem[0] <= i_geo.d2;
            r_res[0]  <= '0;
            r_dist[0] <= r_res[RW];
            r_zero[0] <= r_res[RW] == '0;
            for (int i = 0; i < 3; i++) begin
                r_drem[i][0] <= RW'(w_prod[i][D2W-1:QW]);
                r_nlo[i][0]  <= w_prod[i][QW-1:0];
                r_q[i][0]    <= '0;
                r_out[i]     <= w_out[i];
            end
            r_hit <= r_g[BN-2].hit;
        end
    end

    // integer square root, one result bit per stage
    for (genvar j = 1; j <= RW; j++) begin : g_sqrt
        localparam int B = RW - j;
        logic [D2W+1:0] trial;
        logic           ge;
        assign trial = ((D2W+2)'(r_res[j-1]) << (B + 1)) + ((D2W+2)'(1) << (2 * B));
        assign ge    = (D2W+2)'(r_srem[j-1]) >= trial;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_srem[j] <= ge ? r_srem[j-1] - trial[D2W-1:0] : r_srem[j-1];
                r_res[j]  <= ge ? r_res[j-1] | (RW'(1) << B) : r_res[j-1];
            end
        end
    end

    // three restoring dividers by the distance
    for (genvar k = 1; k <= QW; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            logic [RW:0] rem2;
            logic        ge;
            if (en) begin
                r_dist[k] <= r_dist[k-1];
                r_zero[k] <= r_zero[k-1];
                for (int i = 0; i < 3; i++) begin
                    rem2 = {r_drem[i][k-1], r_nlo[i][k-1][QW-1]};
                    ge   = rem2 >= {1'b0, r_dist[k-1]};
                    r_drem[i][k] <= ge ? RW'(rem2 - {1'b0, r_dist[k-1]}) : RW'(rem2);
                    r_nlo[i][k]  <= r_nlo[i][k-1] << 1;
                    r_q[i][k]    <= {r_q[i][k-1][QW-2:0], ge};
                end
            end
        end
    end

endmodule

@@ hw/rtl/point_capsule_pushout_core.sv @@
// throughput: one vertex per cycle unless the output stalls, set by the fully
// pipelined divider and root stages (16 projection divide stages, 31 root stages,
// 33 push divide stages)
// a four-entry queue lets the classify front keep going while the output stalls
// reset: synchronous, active low; clears all valid flags, the queue and the capsule registers
// ---------------------------------------------------------------------------
// point_capsule_pushout_core
// pushes a streamed vertex out of a configured capsule and flags the hit
// ---------------------------------------------------------------------------
module point_capsule_pushout_core import pcp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [CW-1:0]        i_cfg_data,
    // vertex in
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [CW-1:0] i_vertex_x,
    input  logic signed [CW-1:0] i_vertex_y,
    input  logic signed [CW-1:0] i_vertex_z,
    // corrected vertex out
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [CW-1:0] o_out_x,
    output logic signed [CW-1:0] o_out_y,
    output logic signed [CW-1:0] o_out_z,
    output logic                 o_hit
);

    // capsule registers; the user must write them only while the pipe is empty, the block does not enforce it
    t_capsule r_cap;

    // front to queue and queue to back transfers
    logic f_valid, f_ready;
    t_geo f_geo;
    logic q_valid, q_ready;
    t_geo q_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_END_A_X:    r_cap.ax     <= i_cfg_data;
                REG_END_A_Y:    r_cap.ay     <= i_cfg_data;
                REG_END_A_Z:    r_cap.az     <= i_cfg_data;
                REG_END_B_X:    r_cap.bx     <= i_cfg_data;
                REG_END_B_Y:    r_cap.by     <= i_cfg_data;
                REG_END_B_Z:    r_cap.bz     <= i_cfg_data;
                REG_CAP_RADIUS: r_cap.radius <= i_cfg_data[RW-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // front: projection onto the segment, closest point, inside test
    pcp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cap   (r_cap),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_px    (i_vertex_x),
        .i_py    (i_vertex_y),
        .i_pz    (i_vertex_z),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_geo   (f_geo)
    );

    // decoupling queue
    pcp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_geo),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_geo)
    );

    // back: distance root, push along the normal, clamp; ends in the output register
    pcp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_radius (r_cap.radius),
        .i_valid  (q_valid),
        .o_ready  (q_ready),
        .i_geo    (q_geo),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_x      (o_out_x),
        .o_y      (o_out_y),
        .o_z      (o_out_z),
        .o_hit    (o_hit)
    );

`ifndef NO_ASSERTIONS
    a_rst_out_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");
    a_rst_in_ready: assert property (@(posedge i_clk) !i_rst_n |=> o_in_ready)
        else $error("front not ready straight after reset");
    a_rst_queue_empty: assert property (@(posedge i_clk) !i_rst_n |=> !q_valid)
        else $error("queue not empty straight after reset");
`endif

endmodule
